// File: design/assert_macros.svh
// assertion helper macros for the cache checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: label");

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: label");

`endif

// File: design/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// types and constants shared by the keyed cache modules
// ----------------------------------------------------------------------------
package lkc_pkg;
	localparam int NUM_INSTANCES = 4;
	localparam int ENTRIES_PER_INSTANCE = 512;
	localparam int TOTAL_ENTRIES = NUM_INSTANCES * ENTRIES_PER_INSTANCE;
	localparam int SLOT_W = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
	localparam int OFS_W = $clog2(ENTRIES_PER_INSTANCE);
	localparam int ADDR_W = $clog2(TOTAL_ENTRIES);
	localparam int CNT_W = OFS_W + 1;
	localparam logic [30:0] ID_TOP = 31'h7FFF_FFFF;

	localparam logic [2:0] FUNC_FIND = 3'd0;
	localparam logic [2:0] FUNC_STORE = 3'd1;
	localparam logic [2:0] FUNC_RESERVE = 3'd2;
	localparam logic [2:0] FUNC_CLEAR = 3'd3;
	localparam logic [2:0] FUNC_CLEAR_ALL = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NULL = 2'd1;
	localparam logic [1:0] ST_NO_SLOT = 2'd2;

	typedef struct packed {
		logic [2:0] func;
		logic [63:0] instance_key;
		logic [63:0] text_key;
		logic [31:0] value_handle;
		logic need_fill;
		logic need_stroke;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [31:0] result_handle;
		logic [30:0] fill_id;
		logic [30:0] stroke_id;
		logic [1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SCAN_END,
		S_WRITE,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request
		logic decode;    // resolve slot, handle simple ops
		logic scan_init; // reset scan counter and trackers
		logic scan_step; // issue one entry read
		logic commit;    // apply store/touch at chosen entry
		logic finish;    // drive result strobe
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_scan; // decoded op needs region scan
		logic scan_last; // last read issued
		logic need_write;
	} sts_t;
endpackage

// File: design/lkc_ctrl.sv
// ----------------------------------------------------------------------------
// lkc_ctrl
// sequencer for request decode, region scan and commit
// ----------------------------------------------------------------------------
module lkc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input lkc_pkg::sts_t sts,
	output lkc_pkg::cmd_t cmd,
	output logic busy
);
	import lkc_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_nx = S_DECODE;
			S_DECODE: state_nx = sts.need_scan ? S_SCAN : S_DONE;
			S_SCAN: if (sts.scan_last) state_nx = S_SCAN_END;
			S_SCAN_END: state_nx = sts.need_write ? S_WRITE : S_DONE;
			S_WRITE: state_nx = S_DONE;
			S_DONE: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				cmd.scan_init = 1'b1;
			end
			S_SCAN: cmd.scan_step = 1'b1;
			S_SCAN_END: ;
			S_WRITE: cmd.commit = 1'b1;
			S_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end
endmodule

// File: design/lkc_datapath.sv
// ----------------------------------------------------------------------------
// lkc_datapath
// slot table, entry memories, scan trackers and result register
// ----------------------------------------------------------------------------
module lkc_datapath (
	input logic clk,
	input logic arst_n,
	input lkc_pkg::cmd_t cmd,
	input lkc_pkg::req_t req,
	output lkc_pkg::sts_t sts,
	output logic done,
	output lkc_pkg::rsp_t rsp
);
	import lkc_pkg::*;

	// entry memories, undefined until written
	logic [63:0] mem_key [TOTAL_ENTRIES];
	logic [31:0] mem_handle [TOTAL_ENTRIES];
	logic [63:0] mem_use [TOTAL_ENTRIES];
	// a region fills from offset zero and an eviction refills its victim,
	// so the entries below the slot fill count are exactly the valid ones

	logic [NUM_INSTANCES-1:0] slot_valid_q;
	logic [63:0] slot_key_q [NUM_INSTANCES];
	logic [30:0] slot_next_q [NUM_INSTANCES];
	logic [CNT_W-1:0] slot_fill_q [NUM_INSTANCES];
	logic [63:0] tick_q;

	req_t req_q;
	logic [SLOT_W-1:0] slot_q;
	rsp_t rsp_q;

	// scan pipeline: address issue, registered read data in the following cycle
	logic [OFS_W:0] cnt_q;
	logic rd_v_s1;
	logic [OFS_W-1:0] rd_ofs_s1;
	logic [63:0] rd_key_s1, rd_use_s1;
	logic [31:0] rd_handle_s1;
	logic rd_valid_s1;
	logic hit_q;
	logic [OFS_W-1:0] hit_ofs_q, free_ofs_q, old_ofs_q;
	logic [31:0] hit_handle_q;
	logic free_q, old_v_q;
	logic [63:0] old_use_q;

	// slot lookup
	logic found;
	logic [SLOT_W-1:0] found_s;
	logic freeav;
	logic [SLOT_W-1:0] free_s;
	always_comb begin
		found = 1'b0;
		found_s = '0;
		freeav = 1'b0;
		free_s = '0;
		for (int s = NUM_INSTANCES - 1; s >= 0; s--) begin
			if (slot_valid_q[s] && slot_key_q[s] == req_q.instance_key) begin
				found = 1'b1;
				found_s = SLOT_W'(s);
			end
			if (!slot_valid_q[s]) begin
				freeav = 1'b1;
				free_s = SLOT_W'(s);
			end
		end
	end

	// decoded op needs a region scan, valid while decoding
	logic need_scan;
	assign need_scan = (req_q.func == FUNC_FIND && found) ||
		(req_q.func == FUNC_STORE && req_q.value_handle != 32'd0 && (found || freeav));

	// id allocation for reserve
	logic [30:0] nid0, nid1, nid2, fid, sid;
	always_comb begin
		nid0 = found ? slot_next_q[found_s] : 31'd0;
		fid = '0;
		sid = '0;
		nid1 = nid0;
		if (req_q.need_fill) begin
			fid = (nid1 == 31'd0) ? ID_TOP : nid1;
			nid1 = (fid > 31'd1) ? fid - 31'd1 : fid;
		end
		nid2 = nid1;
		if (req_q.need_stroke) begin
			sid = (nid2 == 31'd0) ? ID_TOP : nid2;
			nid2 = (sid > 31'd1) ? sid - 31'd1 : sid;
		end
	end

	logic [ADDR_W-1:0] base;
	assign base = ADDR_W'(slot_q) << OFS_W;
	logic [ADDR_W-1:0] rd_addr;
	assign rd_addr = base | ADDR_W'(cnt_q[OFS_W-1:0]);

	// write target
	logic [OFS_W-1:0] wofs;
	logic [ADDR_W-1:0] waddr;
	assign wofs = hit_q ? hit_ofs_q : (free_q ? free_ofs_q : old_ofs_q);
	assign waddr = base | ADDR_W'(wofs);

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_key_s1 <= mem_key[rd_addr];
			rd_use_s1 <= mem_use[rd_addr];
			rd_handle_s1 <= mem_handle[rd_addr];
		end
		if (cmd.commit) begin
			mem_use[waddr] <= tick_q;
			if (!hit_q) begin
				mem_key[waddr] <= req_q.text_key;
				mem_handle[waddr] <= req_q.value_handle;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.scan_step) begin
			rd_ofs_s1 <= cnt_q[OFS_W-1:0];
			rd_valid_s1 <= (cnt_q < slot_fill_q[slot_q]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			tick_q <= 64'd1;
			rd_v_s1 <= 1'b0;
			cnt_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			old_v_q <= 1'b0;
			slot_q <= '0;
			rsp_q <= '0;
			for (int s = 0; s < NUM_INSTANCES; s++) begin
				slot_next_q[s] <= '0;
				slot_fill_q[s] <= '0;
				slot_key_q[s] <= '0;
			end
		end else begin
			rd_v_s1 <= cmd.scan_step;
			if (cmd.decode) begin
				rsp_q <= '0;
				case (req_q.func)
					FUNC_FIND: begin
						slot_q <= found_s;
					end
					FUNC_STORE: begin
						if (req_q.value_handle == 32'd0) rsp_q.status <= ST_NULL;
						else if (found) begin
							slot_q <= found_s;
						end else if (freeav) begin
							slot_q <= free_s;
							slot_valid_q[free_s] <= 1'b1;
							slot_key_q[free_s] <= req_q.instance_key;
							slot_next_q[free_s] <= '0;
							slot_fill_q[free_s] <= '0;
						end else rsp_q.status <= ST_NO_SLOT;
					end
					FUNC_RESERVE: begin
						if (found) begin
							slot_next_q[found_s] <= nid2;
							rsp_q.fill_id <= fid;
							rsp_q.stroke_id <= sid;
						end else if (freeav) begin
							slot_valid_q[free_s] <= 1'b1;
							slot_key_q[free_s] <= req_q.instance_key;
							slot_next_q[free_s] <= nid2;
							slot_fill_q[free_s] <= '0;
							rsp_q.fill_id <= fid;
							rsp_q.stroke_id <= sid;
						end else rsp_q.status <= ST_NO_SLOT;
					end
					FUNC_CLEAR: begin
						if (req_q.instance_key != 64'd0 && found) begin
							slot_valid_q[found_s] <= 1'b0;
							slot_next_q[found_s] <= '0;
							slot_fill_q[found_s] <= '0;
						end
					end
					FUNC_CLEAR_ALL: begin
						slot_valid_q <= '0;
						for (int s = 0; s < NUM_INSTANCES; s++) begin
							slot_next_q[s] <= '0;
							slot_fill_q[s] <= '0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.scan_init) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				old_v_q <= 1'b0;
			end
			if (cmd.scan_step) cnt_q <= cnt_q + CNT_W'(1);
			// compare stage on registered read data
			if (rd_v_s1) begin
				if (rd_valid_s1) begin
					if (!hit_q && rd_key_s1 == req_q.text_key) begin
						hit_q <= 1'b1;
						hit_ofs_q <= rd_ofs_s1;
						hit_handle_q <= rd_handle_s1;
					end
					if (!old_v_q || rd_use_s1 < old_use_q) begin
						old_v_q <= 1'b1;
						old_use_q <= rd_use_s1;
						old_ofs_q <= rd_ofs_s1;
					end
				end else if (!free_q) begin
					free_q <= 1'b1;
					free_ofs_q <= rd_ofs_s1;
				end
			end
			if (cmd.commit) begin
				tick_q <= tick_q + 64'd1;
				rsp_q.hit <= hit_q;
				rsp_q.result_handle <= hit_q ? hit_handle_q : req_q.value_handle;
				if (!hit_q && free_q)
					slot_fill_q[slot_q] <= slot_fill_q[slot_q] + CNT_W'(1);
			end
		end
	end

	assign sts.need_scan = need_scan;
	assign sts.scan_last = (cnt_q == CNT_W'(ENTRIES_PER_INSTANCE - 1));
	// the last entry is still in the compare stage when this is looked at
	assign sts.need_write = hit_q || (req_q.func == FUNC_STORE) ||
		(rd_v_s1 && rd_valid_s1 && rd_key_s1 == req_q.text_key);
	assign done = cmd.finish;
	assign rsp = rsp_q;
endmodule

// File: design/lru_keyed_cache_with_id_allocator.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache_with_id_allocator
// per-instance keyed handle cache with lru eviction and image-id allocator
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low. find and store on a
// known or newly claimed instance scan its region one entry per cycle through
// the entry memory read port: after decode the whole region is read, then a
// scan end state and, on a hit or a store, a write state come before done; a
// find miss skips the write state. reserve, clear, clear all, unknown funcs,
// a find on an unknown instance and a rejected store go from decode straight
// to done. the result appears for exactly one cycle with done high and must
// be captured then: the receiver cannot stall it. busy is high from the
// accepting edge through the done cycle and low in the cycle after, so the
// next request is taken in the cycle after done at the earliest. no clearing
// pass is needed after reset: a region fills from offset zero, so a per-slot
// fill count cleared by reset tells which entries are valid.
module lru_keyed_cache_with_id_allocator (
	input logic clk,
	input logic arst_n,
	input logic start,
	input lkc_pkg::req_t req,
	output logic busy,
	output logic done,
	output lkc_pkg::rsp_t rsp
);
	import lkc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	lkc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
	);

	// storage and compare logic
	lkc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req), .sts(sts),
		.done(done), .rsp(rsp)
	);
endmodule

// File: design/lkc_checker.sv
// ----------------------------------------------------------------------------
// lkc_checker
// port-level checks on the request and result handshake
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lkc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input lkc_pkg::rsp_t rsp
);
	import lkc_pkg::*;

	`CHK_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`CHK_IMPL(a_done_busy, clk, arst_n, done, busy)
	`CHK_NEXT(a_done_single, clk, arst_n, done, !done && !busy)
	`CHK_IMPL(a_status_code, clk, arst_n, done, rsp.status != 2'd3)
endmodule

bind lru_keyed_cache_with_id_allocator lkc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// File: verif/tb_lru_keyed_cache_with_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_keyed_cache_with_id_allocator
// checks the keyed cache against a behavioral copy of its lookup, eviction
// and id allocation; requests are random with directed corner cases first
// ----------------------------------------------------------------------------

// scoreboard: behavioral cache state and the queue of expected responses
class cache_scoreboard;
	bit slot_used [lkc_pkg::NUM_INSTANCES];
	bit [63:0] slot_key [lkc_pkg::NUM_INSTANCES];
	bit [30:0] slot_next_id [lkc_pkg::NUM_INSTANCES];
	bit ent_used [lkc_pkg::TOTAL_ENTRIES];
	bit [63:0] ent_key [lkc_pkg::TOTAL_ENTRIES];
	bit [31:0] ent_handle [lkc_pkg::TOTAL_ENTRIES];
	bit [63:0] ent_stamp [lkc_pkg::TOTAL_ENTRIES];
	bit [63:0] use_tick;
	lkc_pkg::rsp_t pending_rsp [$];
	int errors;
	int checked;

	function new();
		foreach (slot_used[s]) begin
			slot_used[s] = 0;
			slot_next_id[s] = '0;
		end
		foreach (ent_used[e]) ent_used[e] = 0;
		use_tick = 64'd1;
		errors = 0;
		checked = 0;
	endfunction

	function int find_slot(bit [63:0] key);
		foreach (slot_used[s])
			if (slot_used[s] && slot_key[s] == key) return s;
		return -1;
	endfunction

	function int claim_slot(bit [63:0] key);
		int s;
		s = find_slot(key);
		if (s >= 0) return s;
		foreach (slot_used[i])
			if (!slot_used[i]) begin
				slot_used[i] = 1;
				slot_key[i] = key;
				slot_next_id[i] = '0;
				return i;
			end
		return -1;
	endfunction

	function void drop_slot(int s);
		for (int i = 0; i < lkc_pkg::ENTRIES_PER_INSTANCE; i++)
			ent_used[s * lkc_pkg::ENTRIES_PER_INSTANCE + i] = 0;
		slot_used[s] = 0;
		slot_next_id[s] = '0;
	endfunction

	function int lookup(int s, bit [63:0] key);
		int b;
		b = s * lkc_pkg::ENTRIES_PER_INSTANCE;
		for (int i = 0; i < lkc_pkg::ENTRIES_PER_INSTANCE; i++)
			if (ent_used[b + i] && ent_key[b + i] == key) return b + i;
		return -1;
	endfunction

	// free entry, else the lru victim (lowest index on tie)
	function int place(int s);
		int b;
		int victim;
		b = s * lkc_pkg::ENTRIES_PER_INSTANCE;
		for (int i = 0; i < lkc_pkg::ENTRIES_PER_INSTANCE; i++)
			if (!ent_used[b + i]) return b + i;
		victim = b;
		for (int i = 1; i < lkc_pkg::ENTRIES_PER_INSTANCE; i++)
			if (ent_stamp[b + i] < ent_stamp[victim]) victim = b + i;
		ent_used[victim] = 0;
		return victim;
	endfunction

	function void touch(int e);
		ent_stamp[e] = use_tick;
		use_tick = use_tick + 64'd1;
	endfunction

	function bit [30:0] next_id(int s);
		bit [30:0] id;
		if (slot_next_id[s] == 0) slot_next_id[s] = lkc_pkg::ID_TOP;
		id = slot_next_id[s];
		if (slot_next_id[s] > 1) slot_next_id[s] = slot_next_id[s] - 1;
		return id;
	endfunction

	function void note_request(lkc_pkg::req_t r);
		lkc_pkg::rsp_t p;
		int s;
		int e;
		p = '0;
		case (r.func)
			lkc_pkg::FUNC_FIND: begin
				s = find_slot(r.instance_key);
				if (s >= 0) begin
					e = lookup(s, r.text_key);
					if (e >= 0) begin
						touch(e);
						p.hit = 1;
						p.result_handle = ent_handle[e];
					end
				end
			end
			lkc_pkg::FUNC_STORE: begin
				if (r.value_handle == 0) p.status = lkc_pkg::ST_NULL;
				else begin
					s = claim_slot(r.instance_key);
					if (s < 0) p.status = lkc_pkg::ST_NO_SLOT;
					else begin
						e = lookup(s, r.text_key);
						if (e >= 0) begin
							touch(e);
							p.hit = 1;
							p.result_handle = ent_handle[e];
						end else begin
							e = place(s);
							ent_used[e] = 1;
							ent_key[e] = r.text_key;
							ent_handle[e] = r.value_handle;
							touch(e);
							p.result_handle = r.value_handle;
						end
					end
				end
			end
			lkc_pkg::FUNC_RESERVE: begin
				s = claim_slot(r.instance_key);
				if (s < 0) p.status = lkc_pkg::ST_NO_SLOT;
				else begin
					if (r.need_fill) p.fill_id = next_id(s);
					if (r.need_stroke) p.stroke_id = next_id(s);
				end
			end
			lkc_pkg::FUNC_CLEAR: begin
				if (r.instance_key != 0) begin
					s = find_slot(r.instance_key);
					if (s >= 0) drop_slot(s);
				end
			end
			lkc_pkg::FUNC_CLEAR_ALL: foreach (slot_used[i]) drop_slot(i);
			default: ;
		endcase
		pending_rsp.push_back(p);
	endfunction

	function void check_response(lkc_pkg::rsp_t a);
		lkc_pkg::rsp_t x;
		if (pending_rsp.size() == 0) begin
			$display("%0t: response with none expected: %h", $time, a);
			errors++;
			return;
		end
		x = pending_rsp.pop_front();
		checked++;
		if (a.hit !== x.hit) begin
			$display("%0t: hit expected %0d actual %0d", $time, x.hit, a.hit);
			errors++;
		end
		if (a.result_handle !== x.result_handle) begin
			$display("%0t: handle expected %h actual %h", $time, x.result_handle,
				a.result_handle);
			errors++;
		end
		if (a.fill_id !== x.fill_id) begin
			$display("%0t: fill id expected %h actual %h", $time, x.fill_id, a.fill_id);
			errors++;
		end
		if (a.stroke_id !== x.stroke_id) begin
			$display("%0t: stroke id expected %h actual %h", $time, x.stroke_id,
				a.stroke_id);
			errors++;
		end
		if (a.status !== x.status) begin
			$display("%0t: status expected %0d actual %0d", $time, x.status, a.status);
			errors++;
		end
	endfunction
endclass

module tb_lru_keyed_cache_with_id_allocator;
	import lkc_pkg::*;

	localparam int RANDOM_REQUESTS = 400;
	localparam int REQ_W = $bits(req_t);
	// store-heavy runs need a full region scan each plus gaps; wide margin
	localparam longint CYCLE_LIMIT = 64'd3_000_000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	cache_scoreboard sb;
	longint cycles;
	int sent;
	// small key pools so that hits, evictions and slot exhaustion occur
	logic [63:0] inst_pool [6];

	lru_keyed_cache_with_id_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// response check and timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) sb.check_response(rsp);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// present one request after a random gap, hold it until accepted
	task automatic send(req_t r);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			req <= REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sb.note_request(r);
		sent++;
		@(negedge clk);
	endtask

	function automatic req_t make_req(logic [2:0] f, logic [63:0] ik, logic [63:0] tk,
		logic [31:0] h, logic nf, logic ns);
		req_t r;
		r.func = f;
		r.instance_key = ik;
		r.text_key = tk;
		r.value_handle = h;
		r.need_fill = nf;
		r.need_stroke = ns;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly well formed traffic on a few instances and text keys
	function automatic req_t random_req();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r = make_req(FUNC_FIND, inst_pool[$urandom_range(0, 5)],
			64'(($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 40))),
			($urandom_range(0, 15) == 0) ? 32'd0 : $urandom, 1'($urandom), 1'($urandom));
		if (pick < 40) r.func = FUNC_FIND;
		else if (pick < 75) r.func = FUNC_STORE;
		else if (pick < 88) r.func = FUNC_RESERVE;
		else if (pick < 94) r.func = FUNC_CLEAR;
		else if (pick < 96) r.func = FUNC_CLEAR_ALL;
		else r.func = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 19) == 0) r.instance_key = rand64();
		return r;
	endfunction

	initial begin
		sb = new();
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		inst_pool[0] = 64'd0;
		inst_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
		inst_pool[2] = 64'd1;
		inst_pool[3] = rand64();
		inst_pool[4] = rand64();
		inst_pool[5] = 64'h8000_0000_0000_0000;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed corner cases
		send(make_req(FUNC_FIND, 64'd5, 64'd1, 32'd7, 1'b0, 1'b0));  // unknown instance
		send(make_req(FUNC_STORE, 64'd5, 64'd1, 32'd0, 1'b0, 1'b0));  // null handle
		send(make_req(FUNC_STORE, 64'd5, 64'd1, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send(make_req(FUNC_STORE, 64'd5, 64'd1, 32'd9, 1'b0, 1'b0));  // present key
		send(make_req(FUNC_FIND, 64'd5, 64'd1, 32'd0, 1'b1, 1'b1));
		send(make_req(FUNC_FIND, 64'd5, '1, 32'd0, 1'b0, 1'b0));
		send(make_req(FUNC_RESERVE, 64'd5, 64'd0, 32'd0, 1'b1, 1'b1));  // reload from top
		send(make_req(FUNC_RESERVE, 64'd0, '1, '1, 1'b0, 1'b1));
		send(make_req(FUNC_RESERVE, '1, 64'd0, 32'd0, 1'b0, 1'b0));
		send(make_req(FUNC_STORE, 64'd6, '1, 32'd3, 1'b1, 1'b1));      // takes the last free slot
		send(make_req(FUNC_RESERVE, 64'd6, 64'd0, 32'd0, 1'b1, 1'b0));  // known instance
		send(make_req(FUNC_CLEAR, 64'd0, 64'd0, 32'd0, 1'b0, 1'b0));    // clear key zero ignored
		send(make_req(FUNC_CLEAR, 64'd77, 64'd0, 32'd0, 1'b0, 1'b0));   // unknown instance
		send(make_req(FUNC_CLEAR, 64'd5, 64'd0, 32'd0, 1'b0, 1'b0));
		send(make_req(FUNC_FIND, 64'd5, 64'd1, 32'd0, 1'b0, 1'b0));
		send(make_req(3'd5, '1, '1, '1, 1'b1, 1'b1));
		send(make_req(3'd7, '1, '1, '1, 1'b1, 1'b1));
		send(make_req(FUNC_CLEAR_ALL, 64'd0, 64'd0, 32'd0, 1'b0, 1'b0));
		send(make_req(FUNC_RESERVE, 64'd0, 64'd0, 32'd0, 1'b1, 1'b1));

		// fill one region past capacity so lru eviction happens
		for (int i = 0; i < ENTRIES_PER_INSTANCE + 24; i++) begin
			if (i % 50 == 7)
				send(make_req(FUNC_FIND, 64'd9, 64'd3, 32'd0, 1'b0, 1'b0));
			else
				send(make_req(FUNC_STORE, 64'd9, 64'(i), $urandom | 32'd1, 1'b0, 1'b0));
		end
		send(make_req(FUNC_CLEAR_ALL, 64'd0, 64'd0, 32'd0, 1'b0, 1'b0));

		for (int i = 0; i < RANDOM_REQUESTS; i++) send(random_req());
		start <= 1'b0;

		// drain, then allow the block's longest latency
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (ENTRIES_PER_INSTANCE + 20) @(posedge clk);
		$display("sent %0d requests and checked %0d responses", sent, sb.checked);
		$display("covered find, store with eviction, id reserve, clears, unused funcs");
		if (sb.errors == 0 && sb.pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
